@@ hdl/char_lcd_write_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// char lcd write sequencer assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the cycle after the antecedent
`define CLWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("char lcd write sequencer check failed");

// consequent must hold later than the antecedent, at the delay of this macro
`define CLWS_ASSERT_AFTER8(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##8 (cons)) \
        else $error("char lcd write sequencer check failed");

`else

`define CLWS_ASSERT_NEXT(label, ante, cons)
`define CLWS_ASSERT_AFTER8(label, ante, cons)

`endif

`endif

@@ hdl/clws_pkg.sv @@
// ----------------------------------------------------------------------------
// clws_pkg
// shared types and constants of the char lcd write sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clws_pkg;

    // request codes
    localparam logic [2:0] ACT_INIT    = 3'd0;
    localparam logic [2:0] ACT_COMMAND = 3'd1;
    localparam logic [2:0] ACT_DATA    = 3'd2;
    localparam logic [2:0] ACT_GOTO    = 3'd3;
    localparam logic [2:0] ACT_NUMBER  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_BUS_MODE    = 2'd0;
    localparam logic [1:0] REG_LINE_LENGTH = 2'd1;

    // display bytes
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'b0011_1000;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'b0010_1000;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'b0000_1100;
    localparam logic [7:0] CMD_CLEAR      = 8'b0000_0001;
    localparam logic [7:0] NIBBLE_4BIT    = 8'h02;
    localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
    localparam logic [7:0] ROW2_OFFSET    = 8'h40;
    localparam logic [7:0] ASCII_MINUS    = 8'h2D;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // sizes
    localparam int unsigned MAX_WRITES  = 24;
    localparam int unsigned WRITE_CNT_W = $clog2(MAX_WRITES + 1);
    localparam int unsigned NUM_DIGITS  = 10;
    localparam int unsigned DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
    localparam int unsigned MAG_W       = 32;
    localparam int unsigned CONV_CNT_W  = $clog2(MAG_W + 1);
    localparam int unsigned POS_W       = 7;
    localparam int unsigned LINE_W      = 6;

    // which byte the datapath puts on the bus
    typedef enum logic [3:0] {
        SEL_NIBBLE_INIT,
        SEL_FUNC,
        SEL_DISPLAY,
        SEL_CLEAR,
        SEL_INPUT_CMD,
        SEL_GOTO,
        SEL_LINE2,
        SEL_HOME,
        SEL_INPUT_CHAR,
        SEL_MINUS,
        SEL_DIGIT
    } byte_sel_t;

    typedef struct packed {
        logic      load;         // latch the incoming item
        logic      req;          // byte write wanted
        byte_sel_t sel;
        logic      final_write;  // byte is the last one of the request
        logic      pos_clear;
        logic      pos_inc;
        logic      digit_shift;  // drop the top decimal digit
    } clws_cmd_t;

    typedef struct packed {
        logic byte_done;       // requested byte fully written or dropped
        logic pos_at_line;
        logic pos_at_end;
        logic conv_done;
        logic top_digit_zero;
        logic one_digit_left;
        logic is_negative;
        logic is_clear_cmd;
        logic four_bit;
    } clws_status_t;

endpackage

`default_nettype wire

@@ hdl/clws_ctrl.sv @@
// ----------------------------------------------------------------------------
// clws_ctrl
// request sequencer: walks each action through its list of bus bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clws_ctrl
    import clws_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [2:0]   action,
    output logic              idle,
    output clws_cmd_t         cmd,
    input  wire clws_status_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_NIBBLE,
        S_INIT_FUNC,
        S_INIT_DISPLAY,
        S_INIT_CLEAR,
        S_COMMAND,
        S_GOTO,
        S_CONVERT,
        S_SKIP_ZEROS,
        S_DATA_LINE2,
        S_DATA_HOME,
        S_DATA_CHAR
    } state_t;

    typedef enum logic [1:0] {
        CH_INPUT,
        CH_MINUS,
        CH_DIGIT
    } char_kind_t;

    state_t     state_reg, state_next;
    char_kind_t kind_reg, kind_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (action)
                        ACT_INIT:
                        begin
                            cmd.pos_clear = 1'b1;
                            state_next    = stat.four_bit ? S_INIT_NIBBLE : S_INIT_FUNC;
                        end
                        ACT_COMMAND: state_next = S_COMMAND;
                        ACT_DATA:
                        begin
                            kind_next  = CH_INPUT;
                            state_next = S_DATA_LINE2;
                        end
                        ACT_GOTO:    state_next = S_GOTO;
                        ACT_NUMBER:  state_next = S_CONVERT;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT_NIBBLE:
            begin
                cmd.req = 1'b1;
                cmd.sel = SEL_NIBBLE_INIT;
                if (stat.byte_done)
                    state_next = S_INIT_FUNC;
            end
            S_INIT_FUNC:
            begin
                cmd.req = 1'b1;
                cmd.sel = SEL_FUNC;
                if (stat.byte_done)
                    state_next = S_INIT_DISPLAY;
            end
            S_INIT_DISPLAY:
            begin
                cmd.req = 1'b1;
                cmd.sel = SEL_DISPLAY;
                if (stat.byte_done)
                    state_next = S_INIT_CLEAR;
            end
            S_INIT_CLEAR:
            begin
                cmd.req         = 1'b1;
                cmd.sel         = SEL_CLEAR;
                cmd.final_write = 1'b1;
                if (stat.byte_done)
                begin
                    cmd.pos_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_COMMAND:
            begin
                cmd.req         = 1'b1;
                cmd.sel         = SEL_INPUT_CMD;
                cmd.final_write = 1'b1;
                if (stat.byte_done)
                begin
                    cmd.pos_clear = stat.is_clear_cmd;
                    state_next    = S_IDLE;
                end
            end
            S_GOTO:
            begin
                cmd.req         = 1'b1;
                cmd.sel         = SEL_GOTO;
                cmd.final_write = 1'b1;
                if (stat.byte_done)
                    state_next = S_IDLE;
            end
            S_CONVERT:
            begin
                if (stat.conv_done)
                begin
                    if (stat.is_negative)
                    begin
                        kind_next  = CH_MINUS;
                        state_next = S_DATA_LINE2;
                    end
                    else
                    begin
                        state_next = S_SKIP_ZEROS;
                    end
                end
            end
            S_SKIP_ZEROS:
            begin
                // leading zeros go, the units digit always stays
                if (stat.top_digit_zero && !stat.one_digit_left)
                begin
                    cmd.digit_shift = 1'b1;
                end
                else
                begin
                    kind_next  = CH_DIGIT;
                    state_next = S_DATA_LINE2;
                end
            end
            S_DATA_LINE2:
            begin
                if (stat.pos_at_line)
                begin
                    cmd.req = 1'b1;
                    cmd.sel = SEL_LINE2;
                    if (stat.byte_done)
                        state_next = S_DATA_HOME;
                end
                else
                begin
                    state_next = S_DATA_HOME;
                end
            end
            S_DATA_HOME:
            begin
                if (stat.pos_at_end)
                begin
                    cmd.req = 1'b1;
                    cmd.sel = SEL_HOME;
                    if (stat.byte_done)
                    begin
                        cmd.pos_clear = 1'b1;
                        state_next    = S_DATA_CHAR;
                    end
                end
                else
                begin
                    state_next = S_DATA_CHAR;
                end
            end
            S_DATA_CHAR:
            begin
                cmd.req = 1'b1;
                case (kind_reg)
                    CH_INPUT: cmd.sel = SEL_INPUT_CHAR;
                    CH_MINUS: cmd.sel = SEL_MINUS;
                    default:  cmd.sel = SEL_DIGIT;
                endcase
                cmd.final_write = (kind_reg == CH_INPUT)
                                  || (kind_reg == CH_DIGIT && stat.one_digit_left);
                if (stat.byte_done)
                begin
                    cmd.pos_inc = 1'b1;
                    case (kind_reg)
                        CH_INPUT: state_next = S_IDLE;
                        CH_MINUS: state_next = S_SKIP_ZEROS;
                        default:
                        begin
                            cmd.digit_shift = 1'b1;
                            state_next      = stat.one_digit_left ? S_IDLE : S_DATA_LINE2;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= CH_INPUT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/clws_datapath.sv @@
// ----------------------------------------------------------------------------
// clws_datapath
// item latch, decimal converter, position counter and bus write emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clws_datapath
    import clws_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        byte_value,
    input  wire logic [5:0]        column,
    input  wire logic              row,
    input  wire logic [MAG_W-1:0]  number,
    input  wire logic              bus_width_mode,
    input  wire logic [LINE_W-1:0] line_length,
    input  wire clws_cmd_t         cmd,
    output clws_status_t           stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_bus_value,
    output logic                   out_reg_select,
    output logic                   out_last
);

    // latched item
    logic [7:0]              byte_reg, byte_next;
    logic [5:0]              col_reg, col_next;
    logic                    row_reg, row_next;
    logic                    neg_reg, neg_next;
    // decimal conversion
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_adj;
    logic [CONV_CNT_W-1:0]   conv_cnt_reg, conv_cnt_next;
    logic [DIGIT_CNT_W-1:0]  digits_reg, digits_next;
    // position and emitter
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [WRITE_CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic                    phase_reg, phase_next;
    logic                    ovalid_reg, ovalid_next;
    logic [7:0]              odata_reg, odata_next;
    logic                    ors_reg, ors_next;
    logic                    olast_reg, olast_next;

    logic [7:0] bus_byte;
    logic       bus_rs;
    logic       single_nibble;
    logic       split;
    logic       part_last;
    logic       capped;
    logic       slot_free;
    logic       fire;

    // double dabble correction, digits are independent
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // byte to write
    always_comb
    begin
        bus_byte      = 8'h00;
        bus_rs        = 1'b0;
        single_nibble = 1'b0;
        case (cmd.sel)
            SEL_NIBBLE_INIT:
            begin
                bus_byte      = NIBBLE_4BIT;
                single_nibble = 1'b1;
            end
            SEL_FUNC:       bus_byte = bus_width_mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
            SEL_DISPLAY:    bus_byte = CMD_DISPLAY_ON;
            SEL_CLEAR:      bus_byte = CMD_CLEAR;
            SEL_INPUT_CMD:  bus_byte = byte_reg;
            SEL_GOTO:       bus_byte = CMD_SET_ADDR + {2'b00, col_reg}
                                       + (row_reg ? ROW2_OFFSET : 8'h00);
            SEL_LINE2:      bus_byte = CMD_SET_ADDR + ROW2_OFFSET;
            SEL_HOME:       bus_byte = CMD_SET_ADDR;
            SEL_INPUT_CHAR:
            begin
                bus_byte = byte_reg;
                bus_rs   = 1'b1;
            end
            SEL_MINUS:
            begin
                bus_byte = ASCII_MINUS;
                bus_rs   = 1'b1;
            end
            SEL_DIGIT:
            begin
                bus_byte = ASCII_ZERO | {4'h0, bcd_reg[BCD_W-1 -: 4]};
                bus_rs   = 1'b1;
            end
            default:        bus_byte = 8'h00;
        endcase
    end

    assign split     = bus_width_mode && !single_nibble;
    assign part_last = !split || phase_reg;
    assign capped    = (wcnt_reg == WRITE_CNT_W'(MAX_WRITES));
    assign slot_free = !ovalid_reg || out_ready;
    assign fire      = cmd.req && !capped && slot_free;

    always_comb
    begin
        byte_next     = byte_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        conv_cnt_next = conv_cnt_reg;
        digits_next   = digits_reg;
        pos_next      = pos_reg;
        wcnt_next     = wcnt_reg;
        phase_next    = phase_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        ors_next      = ors_reg;
        olast_next    = olast_reg;

        if (cmd.load)
        begin
            byte_next     = byte_value;
            col_next      = column;
            row_next      = row;
            neg_next      = number[MAG_W-1];
            mag_next      = number[MAG_W-1] ? (~number + 1'b1) : number;
            bcd_next      = '0;
            conv_cnt_next = CONV_CNT_W'(MAG_W);
            digits_next   = DIGIT_CNT_W'(NUM_DIGITS);
            wcnt_next     = '0;
            phase_next    = 1'b0;
        end
        else
        begin
            if (conv_cnt_reg != '0)
            begin
                bcd_next      = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
                mag_next      = {mag_reg[MAG_W-2:0], 1'b0};
                conv_cnt_next = conv_cnt_reg - 1'b1;
            end
            else if (cmd.digit_shift)
            begin
                bcd_next    = {bcd_reg[BCD_W-5:0], 4'h0};
                digits_next = digits_reg - 1'b1;
            end
            if (fire)
            begin
                wcnt_next  = wcnt_reg + 1'b1;
                phase_next = split && !phase_reg;
            end
        end

        if (cmd.pos_clear)
            pos_next = '0;
        else if (cmd.pos_inc)
            pos_next = pos_reg + 1'b1;

        if (fire)
        begin
            ovalid_next = 1'b1;
            ors_next    = bus_rs;
            if (!split)
                odata_next = bus_byte;
            else if (phase_reg)
                odata_next = {4'h0, bus_byte[3:0]};
            else
                odata_next = {4'h0, bus_byte[7:4]};
            olast_next  = (cmd.final_write && part_last)
                          || (wcnt_reg == WRITE_CNT_W'(MAX_WRITES - 1));
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_cnt_reg <= '0;
            digits_reg   <= '0;
            pos_reg      <= '0;
            wcnt_reg     <= '0;
            phase_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            conv_cnt_reg <= conv_cnt_next;
            digits_reg   <= digits_next;
            pos_reg      <= pos_next;
            wcnt_reg     <= wcnt_next;
            phase_reg    <= phase_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        odata_reg <= odata_next;
        ors_reg   <= ors_next;
        olast_reg <= olast_next;
    end

    assign stat.byte_done      = cmd.req && (capped || (slot_free && part_last));
    assign stat.pos_at_line    = (pos_reg == {1'b0, line_length});
    assign stat.pos_at_end     = (pos_reg == {line_length, 1'b0});
    assign stat.conv_done      = (conv_cnt_reg == '0);
    assign stat.top_digit_zero = (bcd_reg[BCD_W-1 -: 4] == 4'h0);
    assign stat.one_digit_left = (digits_reg == DIGIT_CNT_W'(1));
    assign stat.is_negative    = neg_reg;
    assign stat.is_clear_cmd   = (byte_reg == CMD_CLEAR);
    assign stat.four_bit       = bus_width_mode;

    assign out_valid      = ovalid_reg;
    assign out_bus_value  = odata_reg;
    assign out_reg_select = ors_reg;
    assign out_last       = olast_reg;

endmodule

`default_nettype wire

@@ hdl/char_lcd_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// turns display requests into character-lcd register writes
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one request item: init, raw command, data byte,
//   go to column/row, or signed decimal number; codes 5..7 are dropped
//   m_* channel gives one item per bus write: tdata is the byte (eight-bit
//   bus) or the nibble in bits 3:0 (four-bit bus, high nibble first),
//   tuser is register select, tlast marks the final write of the request
//   cfg_* channel writes bus mode (index 0) and line length (index 1)
//   a request yields at most 24 writes; further writes are dropped but the
//   character position still advances
// timing
//   one request at a time; s_tready is high only while the sequencer idles
//   init, command and go-to writes reach the registered output after acceptance
//   and follow one per cycle while m_tready stays high
//   a data character passes the line-two check and then the home check
//   before its write; a wrap command is written in that check's state
//   a number request runs through the shift-and-add-3 converter, then
//   drops each leading zero digit before it reaches the first digit
//   a stalled m_tready holds the current write and the sequencer waits on it
// reset
//   eight-bit bus, line length 16, position 0, output empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_write_sequencer_defines.svh"

module char_lcd_write_sequencer
    import clws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], byte_value[10:3], column[16:11], row[17], number[49:18]
    input  wire logic [55:0] s_tdata,
    // bus write channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bus_value[7:0]
    output logic [7:0]       m_tdata,
    // reg_select[0]
    output logic             m_tuser,
    output logic             m_tlast,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam logic [LINE_W-1:0] LINE_RESET = 6'd16;

    logic              mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic [2:0]        in_action;
    logic [7:0]        in_byte_value;
    logic [5:0]        in_column;
    logic              in_row;
    logic [MAG_W-1:0]  in_number;

    logic              idle;
    clws_cmd_t         cmd;
    clws_status_t      stat;

    // unpack the request item
    assign in_action     = s_tdata[2:0];
    assign in_byte_value = s_tdata[10:3];
    assign in_column     = s_tdata[16:11];
    assign in_row        = s_tdata[17];
    assign in_number     = s_tdata[49:18];

    // configuration registers, always writable; unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BUS_MODE:    mode_next = cfg_data[0];
                REG_LINE_LENGTH: line_next = cfg_data[LINE_W-1:0];
                default:         mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            line_reg <= LINE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

    // a request is taken only while the sequencer is idle
    assign s_tready = idle;

    clws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (s_tvalid),
        .action (in_action),
        .idle   (idle),
        .cmd    (cmd),
        .stat   (stat)
    );

    clws_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_value     (in_byte_value),
        .column         (in_column),
        .row            (in_row),
        .number         (in_number),
        .bus_width_mode (mode_reg),
        .line_length    (line_reg),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_bus_value  (m_tdata),
        .out_reg_select (m_tuser),
        .out_last       (m_tlast)
    );

    // a known action always keeps the sequencer busy for the next cycle
    `CLWS_ASSERT_NEXT(a_known_action_busy, s_tvalid && s_tready && s_tdata[2:0] <= ACT_NUMBER, !s_tready)

    // an unknown action is dropped without leaving idle
    `CLWS_ASSERT_NEXT(a_unknown_action_idle, s_tvalid && s_tready && s_tdata[2:0] > ACT_NUMBER, s_tready)

    // a number request is still converting when the delayed check samples
    `CLWS_ASSERT_AFTER8(a_number_converts, s_tvalid && s_tready && s_tdata[2:0] == ACT_NUMBER, !s_tready)

endmodule

`default_nettype wire
